@@ design/detector_frame_sample_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the detector frame sample parser
// Shared property wrappers on the block clock.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_FRAME_SAMPLE_PARSER_UNIT_MACROS_SVH
`define DETECTOR_FRAME_SAMPLE_PARSER_UNIT_MACROS_SVH

// Property checked outside reset.
`define DFSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked during reset as well.
`define DFSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Detector frame sample parser package
// Widths, header offsets, register map and result type.
// ----------------------------------------------------------------------------
package dfsp_pkg;

  localparam int unsigned POS_W   = 30;
  localparam int unsigned HLEN_W  = 22;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [POS_W-1:0]  HDR_MIN      = 30'd28;
  localparam logic [HLEN_W-1:0] HDR_MIN_HLEN = 22'd28;

  // Header byte offsets
  localparam logic [4:0] OFS_FLEN_2   = 5'd1;
  localparam logic [4:0] OFS_FLEN_1   = 5'd2;
  localparam logic [4:0] OFS_FLEN_0   = 5'd3;
  localparam logic [4:0] OFS_HLEN_1   = 5'd8;
  localparam logic [4:0] OFS_HLEN_0   = 5'd9;
  localparam logic [4:0] OFS_ITEMS_3  = 5'd12;
  localparam logic [4:0] OFS_ITEMS_2  = 5'd13;
  localparam logic [4:0] OFS_ITEMS_1  = 5'd14;
  localparam logic [4:0] OFS_ITEMS_0  = 5'd15;
  localparam logic [4:0] OFS_EVENT_3  = 5'd22;
  localparam logic [4:0] OFS_EVENT_2  = 5'd23;
  localparam logic [4:0] OFS_EVENT_1  = 5'd24;
  localparam logic [4:0] OFS_EVENT_0  = 5'd25;
  localparam logic [4:0] OFS_BOARD    = 5'd26;
  localparam logic [4:0] OFS_CARD     = 5'd27;

  // Register map (index = paddr[2])
  localparam logic REG_CHANNEL_LIMIT = 1'b0;
  localparam logic [7:0] CHANNEL_LIMIT_RESET = 8'd68;

  typedef struct packed {
    logic [31:0] frame_index;
    logic [31:0] event_id;
    logic [7:0]  board_id;
    logic [7:0]  card_id;
    logic [1:0]  chip_id;
    logic [6:0]  channel;
    logic [8:0]  bucket;
    logic [11:0] adc_value;
  } result_t;

endpackage

@@ design/detector_frame_sample_parser_unit.sv @@
// Output: a kept data word's sample, formed when its last byte is accepted, is
// registered into the output register, or into the skid entry while the output stalls.
// Throughput: one byte per cycle while in_stall is low; each byte needs only
// offset compares and field capture against the frame state registers.
// A two-entry output (result register plus skid) lets bytes flow while a result waits.
// Reset (synchronous, rst high) clears frame state, counters and both output entries.
// ----------------------------------------------------------------------------
// Detector frame sample parser
// Walks the frame header, assembles data words and emits kept samples.
// ----------------------------------------------------------------------------
module detector_frame_sample_parser_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dfsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  frame_index,
  output logic [31:0]                  event_id,
  output logic [7:0]                   board_id,
  output logic [7:0]                   card_id,
  output logic [1:0]                   chip_id,
  output logic [6:0]                   channel,
  output logic [8:0]                   bucket,
  output logic [11:0]                  adc_value
);

  logic [7:0]                        channel_limit;
  logic [dfsp_pkg::POS_W-1:0]        byte_position, byte_position_next;
  logic [dfsp_pkg::POS_W-1:0]        frame_length, frame_length_next;
  logic [dfsp_pkg::HLEN_W-1:0]       header_length, header_length_next;
  logic [31:0]                       items_left, items_left_next;
  logic [31:0]                       header_event, header_event_next;
  logic [7:0]                        header_board, header_board_next;
  logic [7:0]                        header_card, header_card_next;
  logic [23:0]                       word_assembly, word_assembly_next;
  logic [31:0]                       frame_counter, frame_counter_next;

  logic                              in_accept;
  logic                              cfg_write;
  logic [dfsp_pkg::POS_W:0]          pos_inc;
  logic [dfsp_pkg::POS_W:0]          flen_ext;
  logic                              in_header;
  logic [31:0]                       word;
  logic [31:0]                       items_dec;
  logic [dfsp_pkg::HLEN_W-1:0]       hlen_or;
  logic                              keep;
  logic                              end_frame;
  dfsp_pkg::result_t                 result;
  dfsp_pkg::result_t                 out_q, skid_q;
  logic                              skid_valid;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = skid_valid;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  assign prdata = (paddr[2] == dfsp_pkg::REG_CHANNEL_LIMIT) ? {24'd0, channel_limit} : 32'd0;

  assign pos_inc  = {1'b0, byte_position} + 31'd1;
  assign flen_ext = {1'b0, frame_length};
  assign in_header = (byte_position < dfsp_pkg::HDR_MIN) ||
                     (byte_position < {8'd0, header_length});
  assign word      = {word_assembly, data_byte};
  assign items_dec = items_left - 32'd1;
  assign hlen_or   = header_length | {8'd0, data_byte, 6'd0};

  assign result.frame_index = frame_counter;
  assign result.event_id    = header_event;
  assign result.board_id    = header_board;
  assign result.card_id     = header_card;
  assign result.chip_id     = word[31:30];
  assign result.channel     = word[29:23];
  assign result.bucket      = word[22:14];
  assign result.adc_value   = word[11:0];

  always_comb begin
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    header_length_next = header_length;
    items_left_next    = items_left;
    header_event_next  = header_event;
    header_board_next  = header_board;
    header_card_next   = header_card;
    word_assembly_next = word_assembly;
    end_frame          = 1'b0;
    keep               = 1'b0;

    if (in_header) begin
      if (byte_position < dfsp_pkg::HDR_MIN) begin
        unique case (byte_position[4:0])
          dfsp_pkg::OFS_FLEN_2: frame_length_next = {data_byte, 22'd0};
          dfsp_pkg::OFS_FLEN_1: frame_length_next = frame_length | {8'd0, data_byte, 14'd0};
          dfsp_pkg::OFS_FLEN_0: frame_length_next = frame_length | {16'd0, data_byte, 6'd0};
          dfsp_pkg::OFS_HLEN_1: header_length_next = {data_byte, 14'd0};
          dfsp_pkg::OFS_HLEN_0: begin
            header_length_next = (hlen_or < dfsp_pkg::HDR_MIN_HLEN) ?
                                 dfsp_pkg::HDR_MIN_HLEN : hlen_or;
          end
          dfsp_pkg::OFS_ITEMS_3, dfsp_pkg::OFS_ITEMS_2,
          dfsp_pkg::OFS_ITEMS_1, dfsp_pkg::OFS_ITEMS_0:
            items_left_next = {items_left[23:0], data_byte};
          dfsp_pkg::OFS_EVENT_3, dfsp_pkg::OFS_EVENT_2,
          dfsp_pkg::OFS_EVENT_1, dfsp_pkg::OFS_EVENT_0:
            header_event_next = {header_event[23:0], data_byte};
          dfsp_pkg::OFS_BOARD: header_board_next = data_byte;
          dfsp_pkg::OFS_CARD:  header_card_next  = data_byte;
          default: ;
        endcase
      end
      // Header capture is over by offset 27, so the end test sees final values.
      if (pos_inc >= {1'b0, dfsp_pkg::HDR_MIN} && pos_inc >= {9'd0, header_length} &&
          items_left == 32'd0 && pos_inc >= flen_ext) begin
        end_frame = 1'b1;
      end else begin
        byte_position_next = pos_inc[dfsp_pkg::POS_W-1:0];
      end
    end else if (items_left != 32'd0) begin
      if (byte_position[1:0] != 2'b11) begin
        word_assembly_next = word[23:0];
        byte_position_next = pos_inc[dfsp_pkg::POS_W-1:0];
      end else begin
        keep               = {1'b0, word[29:23]} < channel_limit;
        word_assembly_next = 24'd0;
        items_left_next    = items_dec;
        if (items_dec == 32'd0 && pos_inc >= flen_ext) begin
          end_frame = 1'b1;
        end else if (byte_position >= frame_length) begin
          // Past the frame length: cycle within the current word only.
          byte_position_next = byte_position - 30'd3;
        end else begin
          byte_position_next = pos_inc[dfsp_pkg::POS_W-1:0];
        end
      end
    end else begin
      // Padding up to the frame length
      if (pos_inc >= flen_ext) begin
        end_frame = 1'b1;
      end else begin
        byte_position_next = pos_inc[dfsp_pkg::POS_W-1:0];
      end
    end

    frame_counter_next = frame_counter;
    if (end_frame) begin
      frame_counter_next = frame_counter + 32'd1;
      byte_position_next = '0;
      frame_length_next  = '0;
      header_length_next = '0;
      items_left_next    = '0;
      word_assembly_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_limit <= dfsp_pkg::CHANNEL_LIMIT_RESET;
    end else if (cfg_write && paddr[2] == dfsp_pkg::REG_CHANNEL_LIMIT) begin
      channel_limit <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      header_length <= '0;
      items_left    <= '0;
      header_event  <= '0;
      header_board  <= '0;
      header_card   <= '0;
      word_assembly <= '0;
      frame_counter <= '0;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      header_length <= header_length_next;
      items_left    <= items_left_next;
      header_event  <= header_event_next;
      header_board  <= header_board_next;
      header_card   <= header_card_next;
      word_assembly <= word_assembly_next;
      frame_counter <= frame_counter_next;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (in_accept && keep) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (in_accept && keep) begin
        skid_q <= result;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (in_accept && keep) begin
      out_q <= result;
    end
  end

  assign frame_index = out_q.frame_index;
  assign event_id    = out_q.event_id;
  assign board_id    = out_q.board_id;
  assign card_id     = out_q.card_id;
  assign chip_id     = out_q.chip_id;
  assign channel     = out_q.channel;
  assign bucket      = out_q.bucket;
  assign adc_value   = out_q.adc_value;

endmodule

@@ design/dfsp_checker.sv @@
// ----------------------------------------------------------------------------
// Detector frame sample parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "detector_frame_sample_parser_unit_macros.svh"

module dfsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic [dfsp_pkg::ADDR_W-1:0]  paddr,
  input logic [31:0]                  prdata,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [31:0]                  frame_index,
  input logic [6:0]                   channel,
  input logic [11:0]                  adc_value
);

  `DFSP_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall, "output not empty after reset")
  `DFSP_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "stalled beat dropped")
  `DFSP_ASSERT(a_hold_data, out_valid && out_stall |=> $stable(frame_index) && $stable(channel) && $stable(adc_value), "stalled beat changed")
  `DFSP_ASSERT(a_kept_channel, out_valid && paddr[2] == dfsp_pkg::REG_CHANNEL_LIMIT |-> {1'b0, channel} < prdata[7:0], "beat with channel at or above limit")

endmodule

bind detector_frame_sample_parser_unit dfsp_checker u_dfsp_checker (.*);
